// ----- design/pse_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_pkg
// Shared types and constants of the polyline stroke extruder: payload words,
// request/response bundles of the serial arithmetic units, state encodings.
// ----------------------------------------------------------------------------
package pse_pkg;

  // fixed-point formats
  localparam int UNIT_FRAC = 30;            // unit vector fraction bits
  localparam int HW_FRAC   = 16;            // half width fraction bits
  localparam int HW_W      = 20;            // half width register width

  // squared length limit of a degenerate direction sum, unit format
  localparam logic [22:0] UNIT_LIM = 23'd1152922;

  // register map
  typedef enum logic {
    REG_HALF_WIDTH   = 1'b0,
    REG_STROKE_COLOR = 1'b1
  } pse_reg_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic               last_point;
  } pse_in_t;

  typedef struct packed {
    logic signed [31:0] left_x;
    logic signed [31:0] left_y;
    logic signed [31:0] right_x;
    logic signed [31:0] right_y;
    logic [31:0]        vertex_color;
    logic               last_pair;
  } pse_out_t;

  // serial multiplier
  typedef struct packed {
    logic        start;
    logic [31:0] a;
    logic [31:0] b;
  } pse_mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] p;
  } pse_mul_rsp_t;

  // serial square root
  typedef struct packed {
    logic        start;
    logic [63:0] n;
  } pse_sqrt_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] root;
  } pse_sqrt_rsp_t;

  // serial divider
  typedef struct packed {
    logic        start;
    logic [61:0] num;
    logic [31:0] den;
  } pse_div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
  } pse_div_rsp_t;

  // vector normalizer
  typedef struct packed {
    logic               start;
    logic signed [32:0] vx;
    logic signed [32:0] vy;
  } pse_norm_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] ux;
    logic signed [31:0] uy;
  } pse_norm_rsp_t;

  typedef enum logic [3:0] {
    NM_IDLE,
    NM_SHIFT,
    NM_SQX_WAIT,
    NM_SQY_WAIT,
    NM_SQRT_WAIT,
    NM_DIVX_WAIT,
    NM_DIVY_WAIT
  } pse_norm_state_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_N2_GO,
    ST_N2_WAIT,
    ST_SEL,
    ST_N1_GO,
    ST_N1_WAIT,
    ST_SUM,
    ST_NS_GO,
    ST_NS_WAIT,
    ST_DOT1_GO,
    ST_DOT1_WAIT,
    ST_DOT2_GO,
    ST_DOT2_WAIT,
    ST_OX_GO,
    ST_OX_WAIT,
    ST_OY_GO,
    ST_OY_WAIT,
    ST_OUT
  } pse_state_t;

endpackage

// ----- design/polyline_stroke_extruder_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyline_stroke_extruder_core
// Turns a polyline, one point per word, into triangle-strip vertex pairs.
// Output runs one point behind the input.
//
//   channel  direction  handshake            word
//   in       input      in_valid / in_stall  pse_in_t  (point, last flag)
//   out      output     out_valid / out_stall pse_out_t (vertex pair)
//   cfg      input      APB psel/penable      half_width, stroke_color
//
// A line's first point is only held. A middle point takes up to three
// normalizations, each dividing once per component in the serial divider,
// and up to four products. A final point then adds its own pair.
// Reset is synchronous, active low; no clearing pass.
// A stalled output holds its word; the block waits in its output state.
// ----------------------------------------------------------------------------
module polyline_stroke_extruder_core import pse_pkg::*; #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  pse_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output pse_out_t    out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // degenerate segment limit, squared length in coordinate units
  localparam longint unsigned SEG_LIM_L =
    ((64'd1 << (2 * COORD_FRAC_BITS)) + 64'd999999999999) / 64'd1000000000000;
  localparam logic [10:0] SEG_LIM = 11'(SEG_LIM_L);
  // offset rounding shift
  localparam int SH = UNIT_FRAC + HW_FRAC - COORD_FRAC_BITS;
  localparam logic [63:0] RND = 64'd1 << (SH - 1);
  localparam logic signed [31:0] UNIT_ONE = 32'sd1 <<< UNIT_FRAC;

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    mag33 = v[32] ? 33'(-v) : 33'(v);
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    mag32 = v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic seg_deg(input logic signed [32:0] dx,
                                   input logic signed [32:0] dy);
    logic [32:0] ax, ay;
    logic [10:0] sq;
    ax = mag33(dx);
    ay = mag33(dy);
    sq = ({6'd0, ax[4:0]} * {6'd0, ax[4:0]}) + ({6'd0, ay[4:0]} * {6'd0, ay[4:0]});
    seg_deg = (ax[32:5] == 28'd0) && (ay[32:5] == 28'd0) && (sq < SEG_LIM);
  endfunction

  function automatic logic unit_deg(input logic signed [32:0] x,
                                    input logic signed [32:0] y);
    logic [32:0] ax, ay;
    logic [22:0] sq;
    ax = mag33(x);
    ay = mag33(y);
    sq = ({12'd0, ax[10:0]} * {12'd0, ax[10:0]}) + ({12'd0, ay[10:0]} * {12'd0, ay[10:0]});
    unit_deg = (ax[32:11] == 22'd0) && (ay[32:11] == 22'd0) && (sq < UNIT_LIM);
  endfunction

  function automatic logic [31:0] sat32(input logic signed [32:0] v);
    if (v[32] != v[31]) begin
      sat32 = v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  pse_state_t state_r, state_nxt;

  logic [HW_W-1:0]    hw_r;
  logic [31:0]        color_r;
  logic signed [31:0] older_x_r, older_y_r, newer_x_r, newer_y_r;
  logic [1:0]         ps_r;
  logic signed [31:0] px_r, py_r;
  logic               last_r;
  logic               pass_r;
  logic signed [31:0] u1x_r, u1y_r, u2x_r, u2y_r;
  logic signed [31:0] nx_r, ny_r;
  logic signed [61:0] t1_r;
  logic signed [31:0] offx_r, offy_r;
  logic               out_valid_r;
  pse_out_t           out_data_r;

  logic               in_acc, out_free, cfg_wr;
  logic signed [32:0] d1x, d1y, d2x, d2y, sx, sy;
  logic signed [31:0] u2ex, u2ey;
  logic               deg1, deg2, sdeg;
  logic signed [31:0] end_nx, end_ny;
  logic signed [31:0] epx, epy;
  logic signed [61:0] t2;
  logic signed [62:0] dot;
  logic [63:0]        rsum, rsh;
  logic signed [31:0] off_pos;
  pse_norm_req_t      norm_req;
  pse_norm_rsp_t      norm_rsp;
  pse_mul_req_t       mul_req;
  pse_mul_rsp_t       mul_rsp;

  pse_norm u_norm (.clk(clk), .rst_n(rst_n), .req(norm_req), .rsp(norm_rsp));
  pse_mul  u_mul  (.clk(clk), .rst_n(rst_n), .req(mul_req),  .rsp(mul_rsp));

  // handshakes
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;
  assign prdata    = (pse_reg_t'(paddr[2]) == REG_STROKE_COLOR) ? color_r
                                                                : {12'd0, hw_r};

  // segment vectors and their degenerate tests
  assign d2x  = {px_r[31], px_r} - {newer_x_r[31], newer_x_r};
  assign d2y  = {py_r[31], py_r} - {newer_y_r[31], newer_y_r};
  assign d1x  = {newer_x_r[31], newer_x_r} - {older_x_r[31], older_x_r};
  assign d1y  = {newer_y_r[31], newer_y_r} - {older_y_r[31], older_y_r};
  assign deg1 = seg_deg(d1x, d1y);
  assign deg2 = seg_deg(d2x, d2y);

  // direction sum; degenerate outgoing segment repeats the incoming one
  assign u2ex = deg2 ? u1x_r : u2x_r;
  assign u2ey = deg2 ? u1y_r : u2y_r;
  assign sx   = {u1x_r[31], u1x_r} + {u2ex[31], u2ex};
  assign sy   = {u1y_r[31], u1y_r} + {u2ey[31], u2ey};
  assign sdeg = unit_deg(sx, sy);

  // end point normal from the outgoing segment
  assign end_nx = deg2 ? 32'sd0 : -u2y_r;
  assign end_ny = deg2 ? UNIT_ONE : u2x_r;

  // second product of the side test, signed, and the dot product
  assign t2  = (ny_r[31] ^ u1x_r[31]) ? -$signed(mul_rsp.p[61:0])
                                       : $signed(mul_rsp.p[61:0]);
  assign dot = {t1_r[61], t1_r} + {t2[61], t2};

  // offset magnitude, rounded half away from zero
  assign rsum    = mul_rsp.p + RND;
  assign rsh     = rsum >> SH;
  assign off_pos = $signed(rsh[31:0]);

  // emitted point
  assign epx = pass_r ? px_r : newer_x_r;
  assign epy = pass_r ? py_r : newer_y_r;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and unit requests
  always_comb begin
    state_nxt = state_r;
    norm_req  = '0;
    mul_req   = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && ps_r != 2'd0) begin
          state_nxt = ST_N2_GO;
        end
      end
      ST_N2_GO: begin
        if (deg2) begin
          state_nxt = ST_SEL;
        end else begin
          norm_req.start = 1'b1;
          norm_req.vx    = d2x;
          norm_req.vy    = d2y;
          state_nxt      = ST_N2_WAIT;
        end
      end
      ST_N2_WAIT: begin
        if (norm_rsp.done) begin
          state_nxt = ST_SEL;
        end
      end
      ST_SEL: begin
        state_nxt = (ps_r == 2'd1) ? ST_OX_GO : ST_N1_GO;
      end
      ST_N1_GO: begin
        if (deg1) begin
          state_nxt = ST_SUM;
        end else begin
          norm_req.start = 1'b1;
          norm_req.vx    = d1x;
          norm_req.vy    = d1y;
          state_nxt      = ST_N1_WAIT;
        end
      end
      ST_N1_WAIT: begin
        if (norm_rsp.done) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        state_nxt = sdeg ? ST_OX_GO : ST_NS_GO;
      end
      ST_NS_GO: begin
        norm_req.start = 1'b1;
        norm_req.vx    = sx;
        norm_req.vy    = sy;
        state_nxt      = ST_NS_WAIT;
      end
      ST_NS_WAIT: begin
        if (norm_rsp.done) begin
          state_nxt = ST_DOT1_GO;
        end
      end
      ST_DOT1_GO: begin
        mul_req.start = 1'b1;
        mul_req.a     = mag32(nx_r);
        mul_req.b     = mag32(u1y_r);
        state_nxt     = ST_DOT1_WAIT;
      end
      ST_DOT1_WAIT: begin
        if (mul_rsp.done) begin
          state_nxt = ST_DOT2_GO;
        end
      end
      ST_DOT2_GO: begin
        mul_req.start = 1'b1;
        mul_req.a     = mag32(ny_r);
        mul_req.b     = mag32(u1x_r);
        state_nxt     = ST_DOT2_WAIT;
      end
      ST_DOT2_WAIT: begin
        if (mul_rsp.done) begin
          state_nxt = ST_OX_GO;
        end
      end
      ST_OX_GO: begin
        mul_req.start = 1'b1;
        mul_req.a     = {{(32 - HW_W){1'b0}}, hw_r};
        mul_req.b     = mag32(nx_r);
        state_nxt     = ST_OX_WAIT;
      end
      ST_OX_WAIT: begin
        if (mul_rsp.done) begin
          state_nxt = ST_OY_GO;
        end
      end
      ST_OY_GO: begin
        mul_req.start = 1'b1;
        mul_req.a     = {{(32 - HW_W){1'b0}}, hw_r};
        mul_req.b     = mag32(ny_r);
        state_nxt     = ST_OY_WAIT;
      end
      ST_OY_WAIT: begin
        if (mul_rsp.done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_nxt = (!pass_r && last_r) ? ST_OX_GO : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hw_r    <= HW_W'(45875);
      color_r <= 32'hFFFF_FFFF;
    end else if (cfg_wr) begin
      if (pse_reg_t'(paddr[2]) == REG_STROKE_COLOR) begin
        color_r <= pwdata;
      end else begin
        hw_r <= pwdata[HW_W-1:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_OUT && out_free) begin
      out_valid_r             <= 1'b1;
      out_data_r.left_x       <= sat32({epx[31], epx} + {offx_r[31], offx_r});
      out_data_r.left_y       <= sat32({epy[31], epy} + {offy_r[31], offy_r});
      out_data_r.right_x      <= sat32({epx[31], epx} - {offx_r[31], offx_r});
      out_data_r.right_y      <= sat32({epy[31], epy} - {offy_r[31], offy_r});
      out_data_r.vertex_color <= color_r;
      out_data_r.last_pair    <= pass_r;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // line state and datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ps_r      <= 2'd0;
      older_x_r <= 32'sd0;
      older_y_r <= 32'sd0;
      newer_x_r <= 32'sd0;
      newer_y_r <= 32'sd0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            pass_r <= 1'b0;
            if (ps_r == 2'd0) begin
              // first point of a line: just hold it
              newer_x_r <= in_data.point_x;
              newer_y_r <= in_data.point_y;
              ps_r      <= in_data.last_point ? 2'd0 : 2'd1;
            end else begin
              px_r   <= in_data.point_x;
              py_r   <= in_data.point_y;
              last_r <= in_data.last_point;
            end
          end
        end
        ST_N2_WAIT: begin
          if (norm_rsp.done) begin
            u2x_r <= norm_rsp.ux;
            u2y_r <= norm_rsp.uy;
          end
        end
        ST_SEL: begin
          nx_r <= end_nx;
          ny_r <= end_ny;
        end
        ST_N1_GO: begin
          if (deg1) begin
            u1x_r <= 32'sd0;
            u1y_r <= 32'sd0;
          end
        end
        ST_N1_WAIT: begin
          if (norm_rsp.done) begin
            u1x_r <= norm_rsp.ux;
            u1y_r <= norm_rsp.uy;
          end
        end
        ST_SUM: begin
          // opposite directions fall back to the incoming perpendicular
          if (sdeg) begin
            nx_r <= -u1y_r;
            ny_r <= u1x_r;
          end
        end
        ST_NS_WAIT: begin
          if (norm_rsp.done) begin
            nx_r <= -norm_rsp.uy;
            ny_r <= norm_rsp.ux;
          end
        end
        ST_DOT1_WAIT: begin
          // sign of nx * (-u1y)
          if (mul_rsp.done) begin
            t1_r <= (nx_r[31] == u1y_r[31]) ? -$signed(mul_rsp.p[61:0])
                                            : $signed(mul_rsp.p[61:0]);
          end
        end
        ST_DOT2_WAIT: begin
          // keep the normal on the incoming segment's side
          if (mul_rsp.done && dot[62]) begin
            nx_r <= -nx_r;
            ny_r <= -ny_r;
          end
        end
        ST_OX_WAIT: begin
          if (mul_rsp.done) begin
            offx_r <= nx_r[31] ? -off_pos : off_pos;
          end
        end
        ST_OY_WAIT: begin
          if (mul_rsp.done) begin
            offy_r <= ny_r[31] ? -off_pos : off_pos;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            if (!pass_r && last_r) begin
              pass_r <= 1'b1;
              nx_r   <= end_nx;
              ny_r   <= end_ny;
            end else if (last_r) begin
              ps_r <= 2'd0;
            end else begin
              older_x_r <= newer_x_r;
              older_y_r <= newer_y_r;
              newer_x_r <= px_r;
              newer_y_r <= py_r;
              ps_r      <= 2'd2;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- design/pse_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_mul
// Unsigned 32x32 shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module pse_mul import pse_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  pse_mul_req_t req,
  output pse_mul_rsp_t rsp
);

  logic [63:0] acc_r;
  logic [31:0] a_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [32:0] hi_sum;

  // add multiplicand into upper half when the low bit is set
  assign hi_sum = {1'b0, acc_r[63:32]} + (acc_r[0] ? {1'b0, a_r} : 33'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd0;
        acc_r  <= {32'd0, req.b};
        a_r    <= req.a;
      end else if (busy_r) begin
        acc_r <= {hi_sum, acc_r[31:1]};
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.p    = acc_r;

endmodule

// ----- design/pse_sqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_sqrt
// Floor square root of a 64-bit value, one root bit (two radicand bits)
// per cycle.
// ----------------------------------------------------------------------------
module pse_sqrt import pse_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  pse_sqrt_req_t req,
  output pse_sqrt_rsp_t rsp
);

  logic [63:0] n_r;
  logic [31:0] root_r;
  logic [32:0] rem_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [34:0] rem_sh;
  logic [34:0] trial;
  logic        ge;

  assign rem_sh = {rem_r, n_r[63:62]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd0;
        n_r    <= req.n;
        root_r <= 32'd0;
        rem_r  <= 33'd0;
      end else if (busy_r) begin
        rem_r  <= ge ? 33'(rem_sh - trial) : rem_sh[32:0];
        root_r <= {root_r[30:0], ge};
        n_r    <= {n_r[61:0], 2'b00};
        cnt_r  <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.root = root_r;

endmodule

// ----- design/pse_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_div
// Restoring divider, 62-bit numerator by 32-bit denominator, one quotient
// bit per cycle. Quotient is known to fit in 32 bits.
// ----------------------------------------------------------------------------
module pse_div import pse_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  pse_div_req_t req,
  output pse_div_rsp_t rsp
);

  logic [61:0] q_r;      // numerator shifts out, quotient shifts in
  logic [31:0] den_r;
  logic [31:0] rem_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [32:0] rem_sh;
  logic        ge;

  assign rem_sh = {rem_r, q_r[61]};
  assign ge     = (rem_sh >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd0;
        q_r    <= req.num;
        den_r  <= req.den;
        rem_r  <= 32'd0;
      end else if (busy_r) begin
        rem_r <= ge ? 32'(rem_sh - {1'b0, den_r}) : rem_sh[31:0];
        q_r   <= {q_r[60:0], ge};
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd61) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r[31:0];

endmodule

// ----- design/pse_norm.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_norm
// Vector normalizer: scales both magnitudes until the larger sits in
// [2^30, 2^31), takes the length with the serial root unit, then divides
// each component by it with rounding. Result has 30 fraction bits.
// ----------------------------------------------------------------------------
module pse_norm import pse_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  pse_norm_req_t req,
  output pse_norm_rsp_t rsp
);

  pse_norm_state_t state_r, state_nxt;

  logic [32:0]        ax_r, ay_r;
  logic               negx_r, negy_r;
  logic [63:0]        sqx_r;
  logic [31:0]        len_r;
  logic signed [31:0] ux_r, uy_r;
  logic               done_r;

  logic [32:0]   m;
  logic [32:0]   in_ax, in_ay;
  logic [61:0]   num_x, num_y_sqrt, num_y;
  pse_mul_req_t  mul_req;
  pse_mul_rsp_t  mul_rsp;
  pse_sqrt_req_t sqrt_req;
  pse_sqrt_rsp_t sqrt_rsp;
  pse_div_req_t  div_req;
  pse_div_rsp_t  div_rsp;

  pse_mul  u_mul  (.clk(clk), .rst_n(rst_n), .req(mul_req),  .rsp(mul_rsp));
  pse_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .req(sqrt_req), .rsp(sqrt_rsp));
  pse_div  u_div  (.clk(clk), .rst_n(rst_n), .req(div_req),  .rsp(div_rsp));

  assign in_ax = req.vx[32] ? 33'(-req.vx) : 33'(req.vx);
  assign in_ay = req.vy[32] ? 33'(-req.vy) : 33'(req.vy);
  assign m     = (ax_r > ay_r) ? ax_r : ay_r;

  // rounded numerators: mag * 2^30 + len / 2
  assign num_x      = {1'b0, ax_r[30:0], 30'd0} + {31'd0, sqrt_rsp.root[31:1]};
  assign num_y_sqrt = {1'b0, ay_r[30:0], 30'd0} + {31'd0, len_r[31:1]};
  assign num_y      = num_y_sqrt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= NM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and unit requests
  always_comb begin
    state_nxt     = state_r;
    mul_req       = '0;
    sqrt_req      = '0;
    div_req       = '0;
    case (state_r)
      NM_IDLE: begin
        if (req.start && (in_ax != 33'd0 || in_ay != 33'd0)) begin
          state_nxt = NM_SHIFT;
        end
      end
      NM_SHIFT: begin
        if (m[32:31] == 2'b00 && m[30]) begin
          mul_req.start = 1'b1;
          mul_req.a     = ax_r[31:0];
          mul_req.b     = ax_r[31:0];
          state_nxt     = NM_SQX_WAIT;
        end
      end
      NM_SQX_WAIT: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = ay_r[31:0];
          mul_req.b     = ay_r[31:0];
          state_nxt     = NM_SQY_WAIT;
        end
      end
      NM_SQY_WAIT: begin
        if (mul_rsp.done) begin
          sqrt_req.start = 1'b1;
          sqrt_req.n     = sqx_r + mul_rsp.p;
          state_nxt      = NM_SQRT_WAIT;
        end
      end
      NM_SQRT_WAIT: begin
        if (sqrt_rsp.done) begin
          div_req.start = 1'b1;
          div_req.num   = num_x;
          div_req.den   = sqrt_rsp.root;
          state_nxt     = NM_DIVX_WAIT;
        end
      end
      NM_DIVX_WAIT: begin
        if (div_rsp.done) begin
          div_req.start = 1'b1;
          div_req.num   = num_y;
          div_req.den   = len_r;
          state_nxt     = NM_DIVY_WAIT;
        end
      end
      NM_DIVY_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = NM_IDLE;
        end
      end
      default: begin
        state_nxt = NM_IDLE;
      end
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        NM_IDLE: begin
          if (req.start) begin
            ax_r   <= in_ax;
            ay_r   <= in_ay;
            negx_r <= req.vx[32];
            negy_r <= req.vy[32];
            if (in_ax == 33'd0 && in_ay == 33'd0) begin
              ux_r   <= 32'sd0;
              uy_r   <= 32'sd0;
              done_r <= 1'b1;
            end
          end
        end
        NM_SHIFT: begin
          // one binary step per cycle toward [2^30, 2^31)
          if (m[32:31] != 2'b00) begin
            ax_r <= {1'b0, ax_r[32:1]};
            ay_r <= {1'b0, ay_r[32:1]};
          end else if (!m[30]) begin
            ax_r <= {ax_r[31:0], 1'b0};
            ay_r <= {ay_r[31:0], 1'b0};
          end
        end
        NM_SQX_WAIT: begin
          if (mul_rsp.done) begin
            sqx_r <= mul_rsp.p;
          end
        end
        NM_SQRT_WAIT: begin
          if (sqrt_rsp.done) begin
            len_r <= sqrt_rsp.root;
          end
        end
        NM_DIVX_WAIT: begin
          if (div_rsp.done) begin
            ux_r <= negx_r ? -$signed(div_rsp.quot) : $signed(div_rsp.quot);
          end
        end
        NM_DIVY_WAIT: begin
          if (div_rsp.done) begin
            uy_r   <= negy_r ? -$signed(div_rsp.quot) : $signed(div_rsp.quot);
            done_r <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.ux   = ux_r;
  assign rsp.uy   = uy_r;

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for polyline_stroke_extruder_core. Polylines are fed one
// point per word and each vertex pair is compared with a local fixed-point
// model of the extrusion (normals, offsets, saturation), across half width and
// color settings and several handshake idling mixes.
// ----------------------------------------------------------------------------
module tb;
  import pse_pkg::*;

  localparam int FRAC      = 16;
  localparam int IDLE_LIM  = 20000;
  localparam longint SEG_LIM  = ((64'd1 << (2 * FRAC)) + 64'd999999999999) / 64'd1000000000000;
  localparam longint SUM_LIM  = ((64'd1 << 60) + 64'd999999999999) / 64'd1000000000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  pse_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  pse_out_t    out_data;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  polyline_stroke_extruder_core #(.COORD_FRAC_BITS(FRAC)) i_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #4 clk = ~clk;

  // model state
  logic [19:0]  hw_m = 20'd45875;
  logic [31:0]  color_m = 32'hFFFF_FFFF;
  longint       old_x, old_y, cur_x, cur_y;
  int           seen;
  pse_out_t     pair_q[$];
  int           errors = 0;
  int           idle_cycles = 0;
  int           send_idle = 0, recv_stall = 0;

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint root64(longint unsigned n);
    longint unsigned r = 0, b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic bit seg_tiny(longint dx, longint dy);
    longint ax = mag(dx), ay = mag(dy);
    if (ax >= (64'd1 << 24) || ay >= (64'd1 << 24)) return 1'b0;
    return ax * ax + ay * ay < SEG_LIM;
  endfunction

  // unit vector with 30 fraction bits
  task automatic unitize(input longint x, input longint y, output longint ux, output longint uy);
    longint unsigned ax = mag(x), ay = mag(y), m, len, qx, qy;
    m = ax > ay ? ax : ay;
    if (m == 0) begin
      ux = 0; uy = 0;
      return;
    end
    while (m >= (64'd1 << 31)) begin ax >>= 1; ay >>= 1; m >>= 1; end
    while (m < (64'd1 << 30)) begin ax <<= 1; ay <<= 1; m <<= 1; end
    len = root64(ax * ax + ay * ay);
    qx = ((ax << UNIT_FRAC) + len / 2) / len;
    qy = ((ay << UNIT_FRAC) + len / 2) / len;
    ux = x < 0 ? -longint'(qx) : longint'(qx);
    uy = y < 0 ? -longint'(qy) : longint'(qy);
  endtask

  task automatic cap_normal(input longint dx, input longint dy, output longint nx, output longint ny);
    longint ux, uy;
    if (seg_tiny(dx, dy)) begin
      nx = 0; ny = longint'(1) << UNIT_FRAC;
      return;
    end
    unitize(dx, dy, ux, uy);
    nx = -uy; ny = ux;
  endtask

  task automatic joint_normal(input longint ax1, input longint ay1, input longint ax2,
                              input longint ay2, output longint nx, output longint ny);
    longint u1x = 0, u1y = 0, u2x, u2y, sx, sy, vx, vy;
    if (!seg_tiny(ax1, ay1)) unitize(ax1, ay1, u1x, u1y);
    if (!seg_tiny(ax2, ay2)) unitize(ax2, ay2, u2x, u2y);
    else begin u2x = u1x; u2y = u1y; end
    sx = u1x + u2x; sy = u1y + u2y;
    if (mag(sx) * mag(sx) + mag(sy) * mag(sy) < SUM_LIM) begin
      nx = -u1y; ny = u1x;
      return;
    end
    unitize(sx, sy, vx, vy);
    nx = -vy; ny = vx;
    if (nx * (-u1y) + ny * u1x < 0) begin nx = -nx; ny = -ny; end
  endtask

  function automatic longint offset(longint n);
    int sh = UNIT_FRAC + HW_FRAC - FRAC;
    longint unsigned r = (longint'(mag(n)) * hw_m + (64'd1 << (sh - 1))) >> sh;
    return n < 0 ? -longint'(r) : longint'(r);
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  task automatic push_pair(longint px, longint py, longint nx, longint ny, bit fin);
    pse_out_t p;
    longint ox = offset(nx), oy = offset(ny);
    p.left_x = clamp32(px + ox);
    p.left_y = clamp32(py + oy);
    p.right_x = clamp32(px - ox);
    p.right_y = clamp32(py - oy);
    p.vertex_color = color_m;
    p.last_pair = fin;
    pair_q.insert(pair_q.size(), p);
  endtask

  task automatic extrude_point(pse_in_t w);
    longint px = longint'(w.point_x), py = longint'(w.point_y), nx, ny;
    if (seen == 0) begin
      cur_x = px; cur_y = py;
      seen = w.last_point ? 0 : 1;
      return;
    end
    if (seen == 1) cap_normal(px - cur_x, py - cur_y, nx, ny);
    else joint_normal(cur_x - old_x, cur_y - old_y, px - cur_x, py - cur_y, nx, ny);
    push_pair(cur_x, cur_y, nx, ny, 1'b0);
    if (w.last_point) begin
      cap_normal(px - cur_x, py - cur_y, nx, ny);
      push_pair(px, py, nx, ny, 1'b1);
      seen = 0;
    end else begin
      old_x = cur_x; old_y = cur_y; cur_x = px; cur_y = py;
      seen = 2;
    end
  endtask

  // send one word, predicting on acceptance; valid drops only while idling
  task automatic send_point(logic signed [31:0] x, logic signed [31:0] y, bit fin);
    pse_in_t w;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    w.point_x = x; w.point_y = y; w.last_point = fin;
    in_data <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    extrude_point(w);
    @(negedge clk);
  endtask

  task automatic reg_write(pse_reg_t r, logic [31:0] v);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'(r) << 2; pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (r == REG_HALF_WIDTH) hw_m = v[19:0];
    else color_m = v;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pair_q.size() != 0) @(negedge clk);
    repeat (1200) @(negedge clk);
  endtask

  // result check
  always @(posedge clk) begin
    pse_out_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pair_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected pair %h", out_data);
      end else begin
        e = pair_q.pop_front();
        if (out_data !== e) begin
          errors++;
          if (errors <= 10) $display("pair mismatch: exp %h got %h", e, out_data);
        end
      end
    end
  end

  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_stall);

  // watchdog on accepted words
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIM) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(4))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(4000000)) - 2000000);
    endcase
  endfunction

  task automatic test_directed();
    send_point(32'sd0, 32'sd0, 1'b1);             // lone point
    send_point(32'sd0, 32'sd0, 1'b0);             // zero-length end segment
    send_point(32'sd0, 32'sd0, 1'b1);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0); // saturation at max
    send_point(32'h8000_0000, 32'h8000_0000, 1'b0);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    send_point(32'sd0, 32'sd0, 1'b0);             // reversal
    send_point(32'sd65536, 32'sd0, 1'b0);
    send_point(32'sd0, 32'sd0, 1'b1);
    send_point(32'sd0, 32'sd0, 1'b0);             // degenerate in, then out
    send_point(32'sd0, 32'sd0, 1'b0);
    send_point(32'sd100000, 32'sd30000, 1'b0);
    send_point(32'sd100000, 32'sd30000, 1'b0);
    send_point(-32'sd5, 32'sd70000, 1'b0);
    send_point(32'sd1, 32'sd1, 1'b1);             // tiny but nonzero
    drain();
  endtask

  task automatic test_random(int n);
    int len;
    logic signed [31:0] x, y;
    while (n > 0) begin
      len = $urandom_range(8, 1);
      x = rnd_coord(); y = rnd_coord();
      for (int i = 0; i < len; i++) begin
        send_point(x, y, i == len - 1);
        n--;
        if ($urandom_range(9) == 0) begin x = x; y = y; end
        else if ($urandom_range(3) == 0) begin x = rnd_coord(); y = rnd_coord(); end
        else begin
          x = x + 32'($signed($urandom_range(400000)) - 200000);
          y = y + 32'($signed($urandom_range(400000)) - 200000);
        end
      end
    end
    drain();
  endtask

  task automatic test_settings();
    reg_write(REG_HALF_WIDTH, 32'h000F_FFFF);
    reg_write(REG_STROKE_COLOR, 32'h0000_0000);
    test_random(60);
    reg_write(REG_HALF_WIDTH, 32'h0);
    reg_write(REG_STROKE_COLOR, $urandom);
    test_random(60);
    reg_write(REG_HALF_WIDTH, $urandom);
    test_random(60);
  endtask

  initial begin
    seen = 0; old_x = 0; old_y = 0; cur_x = 0; cur_y = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_settings();
    reg_write(REG_HALF_WIDTH, 32'd45875);
    reg_write(REG_STROKE_COLOR, 32'h1234_5678);
    send_idle = 0;  recv_stall = 0;  test_random(140);
    send_idle = 52; recv_stall = 0;  test_random(140);
    send_idle = 0;  recv_stall = 52; test_random(140);
    send_idle = 30; recv_stall = 30; test_random(140);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/pse_pkg.sv
design/pse_mul.sv
design/pse_sqrt.sv
design/pse_div.sv
design/pse_norm.sv
design/polyline_stroke_extruder_core.sv
tb/sv/tb.sv
